FILE: rtl/lrupr_pkg.sv
// Shared constants and types for the LRU page replacement block.
package lrupr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;

    localparam int IDX_W = $clog2(MAX_FRAMES);       // frame number
    localparam int RANK_W = IDX_W;                   // 0 .. MAX_FRAMES-1
    localparam int OLD_W = IDX_W + 1;                // rank or MAX_FRAMES
    localparam int N_W = $clog2(MAX_FRAMES + 1);     // active frame count
    localparam int CFG_W = 4;
    localparam int CNT_W = 16;

    localparam logic [CFG_W-1:0]  FRAMES_RESET = CFG_W'(3);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);
    localparam logic [OLD_W-1:0]  RANK_EMPTY = OLD_W'(MAX_FRAMES);
    localparam logic [CNT_W-1:0]  CNT_SAT = {CNT_W{1'b1}};

    // Search results rippled from frame 0 upward.
    typedef struct packed {
        logic                 hit_found;
        logic [IDX_W-1:0]     hit_idx;
        logic [RANK_W-1:0]    hit_rank;
        logic                 empty_found;
        logic [IDX_W-1:0]     empty_idx;
        logic [RANK_W-1:0]    best_rank;
        logic [IDX_W-1:0]     best_idx;
        logic [PAGE_BITS-1:0] best_page;
    } chain_t;

    // Update broadcast to every frame cell.
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic [OLD_W-1:0]     old_rank;
        logic                 write_page;
        logic [PAGE_BITS-1:0] page;
    } upd_t;

endpackage

FILE: rtl/lru_page_replacement.sv
// Top level: LRU page replacement over a chain of frame cells.
// An accepted beat is held in page_reg until its result loads the output registers.
// Throughput: one beat per cycle while out_stall is low; the search ripples through
//   all frame cells combinationally, so the cell count sets the critical path.
// Reset: all frames empty, ranks and counters zero, frames_reg = 3.
module lru_page_replacement
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [lrupr_pkg::CFG_W-1:0]         cfg_wr_data,
    // reference beats
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]     page_number,
    // result beats
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                replaced,
    output logic [lrupr_pkg::PAGE_BITS-1:0]     victim_page,
    output logic [lrupr_pkg::IDX_W-1:0]         frame_index,
    output logic [lrupr_pkg::CNT_W-1:0]         fault_total,
    output logic [lrupr_pkg::CNT_W-1:0]         replace_total
);

    localparam int MF = lrupr_pkg::MAX_FRAMES;

    logic [lrupr_pkg::CFG_W-1:0]     frames_reg;
    logic [lrupr_pkg::CFG_W-1:0]     frames_next;
    logic                            pend_reg;      // input beat held
    logic                            pend_next;
    logic [lrupr_pkg::PAGE_BITS-1:0] page_reg;
    logic [lrupr_pkg::PAGE_BITS-1:0] page_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            hit_reg;
    logic                            hit_next;
    logic                            repl_reg;
    logic                            repl_next;
    logic [lrupr_pkg::PAGE_BITS-1:0] victim_reg;
    logic [lrupr_pkg::PAGE_BITS-1:0] victim_next;
    logic [lrupr_pkg::IDX_W-1:0]     fidx_reg;
    logic [lrupr_pkg::IDX_W-1:0]     fidx_next;
    logic [lrupr_pkg::CNT_W-1:0]     fault_reg;
    logic [lrupr_pkg::CNT_W-1:0]     fault_next;
    logic [lrupr_pkg::CNT_W-1:0]     rcnt_reg;
    logic [lrupr_pkg::CNT_W-1:0]     rcnt_next;

    logic                            fire;          // held beat resolves now
    logic                            in_accept;
    logic [lrupr_pkg::N_W-1:0]       n_eff;
    logic [MF-1:0]                   active;
    lrupr_pkg::chain_t               chain [MF+1];
    lrupr_pkg::chain_t               res;
    lrupr_pkg::upd_t                 upd;
    logic                            is_fill;
    logic                            is_repl;

    // One held beat; it resolves when the output register is free or drains.
    assign fire      = pend_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = pend_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    // Active frame count: 0 acts as 1, anything above the cell count clamps.
    always_comb
    begin
        if (frames_reg == '0)
            n_eff = lrupr_pkg::N_W'(1);
        else if (32'(frames_reg) > 32'(MF))
            n_eff = lrupr_pkg::N_W'(MF);
        else
            n_eff = lrupr_pkg::N_W'(frames_reg);
    end

    assign chain[0] = '0;

    for (genvar gi = 0; gi < MF; gi++)
    begin : g_cell
        assign active[gi] = (lrupr_pkg::N_W'(gi) < n_eff);

        lrupr_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_idx    (lrupr_pkg::IDX_W'(gi)),
            .active      (active[gi]),
            .lookup_page (page_reg),
            .chain_in    (chain[gi]),
            .chain_out   (chain[gi+1]),
            .upd         (upd)
        );
    end

    assign res = chain[MF];

    // Decide: hit, fill the lowest empty frame, or evict the oldest.
    always_comb
    begin
        is_fill = !res.hit_found && res.empty_found;
        is_repl = !res.hit_found && !res.empty_found;

        upd.en         = fire;
        upd.page       = page_reg;
        upd.write_page = !res.hit_found;
        if (res.hit_found)
        begin
            upd.idx      = res.hit_idx;
            upd.old_rank = {1'b0, res.hit_rank};
        end
        else if (is_fill)
        begin
            upd.idx      = res.empty_idx;
            upd.old_rank = lrupr_pkg::RANK_EMPTY;   // empty frame is oldest
        end
        else
        begin
            upd.idx      = res.best_idx;
            upd.old_rank = {1'b0, res.best_rank};
        end
    end

    always_comb
    begin
        frames_next    = cfg_wr_en ? cfg_wr_data : frames_reg;
        pend_next      = pend_reg;
        page_next      = page_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        repl_next      = repl_reg;
        victim_next    = victim_reg;
        fidx_next      = fidx_reg;
        fault_next     = fault_reg;
        rcnt_next      = rcnt_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (fire)
        begin
            pend_next      = 1'b0;
            out_valid_next = 1'b1;
            hit_next       = res.hit_found;
            repl_next      = is_repl;
            victim_next    = is_repl ? res.best_page : '0;
            fidx_next      = upd.idx;
            if (!res.hit_found && (fault_reg != lrupr_pkg::CNT_SAT))
                fault_next = fault_reg + 1'b1;
            if (is_repl && (rcnt_reg != lrupr_pkg::CNT_SAT))
                rcnt_next = rcnt_reg + 1'b1;
        end
        if (in_accept)
        begin
            pend_next = 1'b1;
            page_next = page_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= lrupr_pkg::FRAMES_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            fault_reg     <= '0;
            rcnt_reg      <= '0;
        end
        else
        begin
            frames_reg    <= frames_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            fault_reg     <= fault_next;
            rcnt_reg      <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg   <= page_next;
        hit_reg    <= hit_next;
        repl_reg   <= repl_next;
        victim_reg <= victim_next;
        fidx_reg   <= fidx_next;
    end

    // Counters move only when a result loads, so they track the output beat.
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign replaced      = repl_reg;
    assign victim_page   = victim_reg;
    assign frame_index   = fidx_reg;
    assign fault_total   = fault_reg;
    assign replace_total = rcnt_reg;

    // A result is a hit or an eviction, never both.
    a_hit_xor_repl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && repl_reg))
        else $error("hit and replaced both set");

    // Every eviction is also a fault.
    a_repl_le_fault: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= fault_reg)
        else $error("replace count above fault count");

    // A hit leaves the fault count unchanged.
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.hit_found) |=> $stable(fault_reg))
        else $error("fault counted on a hit");

endmodule

FILE: rtl/lrupr_cell.sv
// One frame cell: page, valid flag, recency rank, and its search stage.
module lrupr_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [lrupr_pkg::IDX_W-1:0]    cell_idx,
    input  logic                           active,
    input  logic [lrupr_pkg::PAGE_BITS-1:0] lookup_page,
    input  lrupr_pkg::chain_t              chain_in,
    output lrupr_pkg::chain_t              chain_out,
    input  lrupr_pkg::upd_t                upd
);

    logic [lrupr_pkg::PAGE_BITS-1:0] page_reg;
    logic [lrupr_pkg::PAGE_BITS-1:0] page_next;
    logic                            valid_reg;
    logic                            valid_next;
    logic [lrupr_pkg::RANK_W-1:0]    rank_reg;
    logic [lrupr_pkg::RANK_W-1:0]    rank_next;

    // search stage
    always_comb
    begin
        chain_out = chain_in;
        if (active && valid_reg && (page_reg == lookup_page) && !chain_in.hit_found)
        begin
            chain_out.hit_found = 1'b1;
            chain_out.hit_idx   = cell_idx;
            chain_out.hit_rank  = rank_reg;
        end
        if (active && !valid_reg && !chain_in.empty_found)
        begin
            chain_out.empty_found = 1'b1;
            chain_out.empty_idx   = cell_idx;
        end
        // frame 0 seeds the oldest candidate, so all-equal ranks pick it
        if (active && ((rank_reg > chain_in.best_rank) || (cell_idx == '0)))
        begin
            chain_out.best_rank = rank_reg;
            chain_out.best_idx  = cell_idx;
            chain_out.best_page = page_reg;
        end
    end

    // update
    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.en && active)
        begin
            if (cell_idx == upd.idx)
            begin
                rank_next = '0;
                if (upd.write_page)
                begin
                    page_next  = upd.page;
                    valid_next = 1'b1;
                end
            end
            else if (valid_reg && ({1'b0, rank_reg} < upd.old_rank)
                     && (rank_reg != lrupr_pkg::RANK_MAX))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule
